// ===== rtl/hsv2rgb_pkg.sv =====
// Shared types, widths and constants of the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 15;
  localparam int unsigned FracW = 9;
  localparam int unsigned ChW   = 8;

  localparam logic [HueW-1:0]  HueMax     = 15'd23039;
  localparam logic [FracW-1:0] FracOne    = 9'd256;
  localparam logic [11:0]      SectorSpan = 12'd3840;
  localparam logic [ChW-1:0]   ChMax      = 8'd255;

  // Product of value and saturation, in units of 1/65536.
  localparam int unsigned ChromaW = 17;
  // Channel sums, in units of 1/(65536*3840).
  localparam int unsigned SumW = 28;
  localparam logic [SumW-1:0] SumMax = 28'd251658240;

  typedef enum logic [2:0] {
    SecRedYellow    = 3'd0,
    SecYellowGreen  = 3'd1,
    SecGreenCyan    = 3'd2,
    SecCyanBlue     = 3'd3,
    SecBlueMagenta  = 3'd4,
    SecMagentaRed   = 3'd5
  } sector_e;

endpackage

// ===== rtl/hsv2rgb_if.sv =====
// Valid/ready channel interfaces for HSV pixels in and RGB pixels out.
interface hsv2rgb_hsv_if import hsv2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [FracW-1:0] saturation;
  logic [FracW-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if import hsv2rgb_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] red;
  logic [ChW-1:0] green;
  logic [ChW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// Four-stage pipelined HSV to RGB pixel converter.
//
// The block takes one HSV pixel per transfer on pix_i (hue in 1/64 degree,
// saturation and value as Q1.8 fractions) and returns one RGB pixel with
// 8-bit channels per transfer on rgb_o. Out-of-range inputs are clamped.
// Throughput is one pixel per cycle while rgb_o does not stall: the four
// register stages are set by the value times saturation multiply, the
// chroma times sector position multiply, the per-sector channel select
// with the offset add, and the final channel scaling, one of them per
// stage.
// All stages advance together whenever the output register is empty or its
// pixel is taken, so pix_i.ready is high in exactly those cycles.
// When the receiver stalls, the whole pipeline holds its contents and the
// output pixel stays on rgb_o; nothing is lost or repeated.
// Reset clears all stage valid bits, so the pipeline starts empty and
// pix_i.ready is high in the first cycle after reset.
module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsv2rgb_hsv_if.sink    pix_i,
  hsv2rgb_rgb_if.source  rgb_o
);

  logic       adv;
  logic [3:0] vld_d, vld_q;

  // Stage 1 signals.
  logic [HueW-1:0]    hue_c;
  logic [FracW-1:0]   sat_c, val_c;
  logic [17:0]        vs_prod;
  logic [HueW-1:0]    base;
  logic [11:0]        frac;
  sector_e            sec_d1;
  logic [12:0]        t_d1;
  sector_e            sec1_q;
  logic [12:0]        t1_q;
  logic [ChromaW-1:0] c1_q;
  logic [FracW-1:0]   v1_q;

  // Stage 2 signals.
  logic [29:0]        xt_prod;
  logic [ChromaW-1:0] m_diff;
  logic [SumW:0]      cn_d, mn_d;
  sector_e            sec2_q;
  logic [SumW-1:0]    cn2_q, xn2_q, mn2_q;

  // Stage 3 signals.
  logic [SumW-1:0]    r_base, g_base, b_base;
  logic [SumW:0]      r_sum, g_sum, b_sum;
  logic [SumW-1:0]    r3_q, g3_q, b3_q;

  // Stage 4 signals.
  logic [ChW-1:0]     r_d4, g_d4, b_d4;
  logic [ChW-1:0]     r4_q, g4_q, b4_q;

  function automatic logic [ChW-1:0] scale_ch(input logic [SumW-1:0] sum);
    logic [SumW+4:0] prod;
    logic [8:0]      q;
    prod = {1'b0, sum, 4'b0} + {5'b0, sum};
    q    = prod[SumW+4:24];
    return (q > {1'b0, ChMax}) ? ChMax : q[ChW-1:0];
  endfunction

  assign adv         = !vld_q[3] || rgb_o.ready;
  assign pix_i.ready = adv;
  assign vld_d       = {vld_q[2:0], pix_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: clamp, sector split, chroma.
  always_comb begin
    hue_c   = (pix_i.hue > HueMax) ? HueMax : pix_i.hue;
    sat_c   = (pix_i.saturation > FracOne) ? FracOne : pix_i.saturation;
    val_c   = (pix_i.brightness > FracOne) ? FracOne : pix_i.brightness;
    vs_prod = 18'(sat_c) * 18'(val_c);
    if (hue_c >= HueW'(5 * 3840)) begin
      sec_d1 = SecMagentaRed;
      base   = HueW'(5 * 3840);
    end else if (hue_c >= HueW'(4 * 3840)) begin
      sec_d1 = SecBlueMagenta;
      base   = HueW'(4 * 3840);
    end else if (hue_c >= HueW'(3 * 3840)) begin
      sec_d1 = SecCyanBlue;
      base   = HueW'(3 * 3840);
    end else if (hue_c >= HueW'(2 * 3840)) begin
      sec_d1 = SecGreenCyan;
      base   = HueW'(2 * 3840);
    end else if (hue_c >= HueW'(3840)) begin
      sec_d1 = SecYellowGreen;
      base   = HueW'(3840);
    end else begin
      sec_d1 = SecRedYellow;
      base   = '0;
    end
    frac = 12'(hue_c - base);
    t_d1 = sec_d1[0] ? ({1'b0, SectorSpan} - {1'b0, frac}) : {1'b0, frac};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec1_q <= sec_d1;
      t1_q   <= t_d1;
      c1_q   <= vs_prod[ChromaW-1:0];
      v1_q   <= val_c;
    end
  end

  // Stage 2: x term, chroma and offset terms scaled by the sector span.
  always_comb begin
    xt_prod = 30'(c1_q) * 30'(t1_q);
    m_diff  = {v1_q[ChromaW-9:0], 8'b0} - c1_q;
    cn_d    = {c1_q, 12'b0} - {4'b0, c1_q, 8'b0};
    mn_d    = {m_diff, 12'b0} - {4'b0, m_diff, 8'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec2_q <= sec1_q;
      xn2_q  <= xt_prod[SumW-1:0];
      cn2_q  <= cn_d[SumW-1:0];
      mn2_q  <= mn_d[SumW-1:0];
    end
  end

  // Stage 3: place chroma and x per sector and add the offset.
  always_comb begin
    case (sec2_q) inside
      SecRedYellow, SecMagentaRed:   r_base = cn2_q;
      SecYellowGreen, SecBlueMagenta: r_base = xn2_q;
      default:                       r_base = '0;
    endcase
    case (sec2_q) inside
      SecRedYellow, SecCyanBlue:     g_base = xn2_q;
      SecYellowGreen, SecGreenCyan:  g_base = cn2_q;
      default:                       g_base = '0;
    endcase
    case (sec2_q) inside
      SecGreenCyan, SecMagentaRed:   b_base = xn2_q;
      SecCyanBlue, SecBlueMagenta:   b_base = cn2_q;
      default:                       b_base = '0;
    endcase
    r_sum = {1'b0, r_base} + {1'b0, mn2_q};
    g_sum = {1'b0, g_base} + {1'b0, mn2_q};
    b_sum = {1'b0, b_base} + {1'b0, mn2_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r3_q <= r_sum[SumW-1:0];
      g3_q <= g_sum[SumW-1:0];
      b3_q <= b_sum[SumW-1:0];
    end
  end

  // Stage 4: 255/(65536*3840) equals 17/2^24, so scaling is a shift-add.
  always_comb begin
    r_d4 = scale_ch(r3_q);
    g_d4 = scale_ch(g3_q);
    b_d4 = scale_ch(b3_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r4_q <= r_d4;
      g4_q <= g_d4;
      b4_q <= b_d4;
    end
  end

  assign rgb_o.valid = vld_q[3];
  assign rgb_o.red   = r4_q;
  assign rgb_o.green = g4_q;
  assign rgb_o.blue  = b4_q;

`ifndef ASSERT_OFF
  // An accepted pixel always occupies the first stage in the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> vld_q[0])
    else $error("accepted pixel missing from first stage");

  // A stalled pipeline keeps its occupancy.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline occupancy changed during stall");

  // Channel sums never exceed full scale, so saturation stays idle.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (r3_q <= SumMax) && (g3_q <= SumMax) && (b3_q <= SumMax))
    else $error("channel sum above full scale");
`endif

endmodule
